// ===== rtl/core/dllm_pkg.sv =====
`timescale 1ns / 1ps

package dllm_pkg;

  // field widths fixed by the transaction formats
  localparam int unsigned OPC_W  = 4;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned CNT_W  = 7;

  // operation codes
  localparam logic [OPC_W-1:0] OP_INS_HEAD  = 4'd0;
  localparam logic [OPC_W-1:0] OP_INS_TAIL  = 4'd1;
  localparam logic [OPC_W-1:0] OP_INS_AFTER = 4'd2;
  localparam logic [OPC_W-1:0] OP_RM_HEAD   = 4'd3;
  localparam logic [OPC_W-1:0] OP_RM_NODE   = 4'd4;
  localparam logic [OPC_W-1:0] OP_RM_ALL    = 4'd5;
  localparam logic [OPC_W-1:0] OP_GET_HEAD  = 4'd6;
  localparam logic [OPC_W-1:0] OP_GET_TAIL  = 4'd7;
  localparam logic [OPC_W-1:0] OP_GET_PREV  = 4'd8;
  localparam logic [OPC_W-1:0] OP_GET_NEXT  = 4'd9;

  // one result transaction
  typedef struct packed {
    logic [CNT_W-1:0]  node_count;
    logic              result_valid;
    logic [NODE_W-1:0] result_node;
  } result_t;

endpackage

// ===== rtl/core/dllm_link_ram.sv =====
`timescale 1ns / 1ps

module dllm_link_ram #(
  parameter int unsigned AW    = 7,
  parameter int unsigned DEPTH = 65
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  // read-first: a same-address read returns the old entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dllm_out_slot.sv =====
`timescale 1ns / 1ps

module dllm_out_slot (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dllm_pkg::result_t load_data,
  output logic             free,
  output logic             m_valid,
  input  logic             m_ready,
  output dllm_pkg::result_t m_data
);

  assign free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_data <= load_data;
    end
  end

endmodule

// ===== rtl/core/dllm_seq.sv =====
`timescale 1ns / 1ps

module dllm_seq #(
  parameter int unsigned NODE_POOL = 64,
  parameter int unsigned AW        = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dllm_pkg::OPC_W-1:0]      in_opcode,
  input  logic [dllm_pkg::NODE_W-1:0]     in_node,
  input  logic [dllm_pkg::NODE_W-1:0]     in_ref,
  input  logic                            out_free,
  output logic                            out_load,
  output dllm_pkg::result_t               out_data,
  output logic                            next_we,
  output logic [AW-1:0]                   next_waddr,
  output logic [AW-1:0]                   next_wdata,
  output logic [AW-1:0]                   next_raddr,
  input  logic [AW-1:0]                   next_rdata,
  output logic                            prev_we,
  output logic [AW-1:0]                   prev_waddr,
  output logic [AW-1:0]                   prev_wdata,
  output logic [AW-1:0]                   prev_raddr,
  input  logic [AW-1:0]                   prev_rdata
);

  localparam logic [AW-1:0] SENT = AW'(NODE_POOL);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD1  = 3'd2;
  localparam logic [2:0] ST_RD2  = 3'd3;
  localparam logic [2:0] ST_WR1  = 3'd4;
  localparam logic [2:0] ST_WALK = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]                       state;
  logic [AW-1:0]                    clr_idx;
  logic [dllm_pkg::OPC_W-1:0]       op_q;
  logic [AW-1:0]                    n_q;
  logic [AW-1:0]                    r_q;
  logic [AW-1:0]                    a_q;
  logic [AW-1:0]                    b_q;
  logic                             act_q;
  logic [AW-1:0]                    res_q;
  logic                             resv_q;
  logic [dllm_pkg::CNT_W-1:0]       cnt;
  logic [dllm_pkg::CNT_W-1:0]       cnt_next;
  logic [dllm_pkg::CNT_W-1:0]       rem;

  logic          n_ok_in;
  logic          r_ok_in;
  logic          act_in;
  logic [AW-1:0] n_in;
  logic [AW-1:0] r_in;
  logic          accept;
  logic          commit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == ST_FIN) && out_free;

  assign n_ok_in = 32'(in_node) < 32'(NODE_POOL);
  assign r_ok_in = 32'(in_ref) < 32'(NODE_POOL);
  assign n_in    = AW'(in_node);
  assign r_in    = AW'(in_ref);

  always_comb begin
    case (in_opcode)
      dllm_pkg::OP_INS_HEAD, dllm_pkg::OP_INS_TAIL, dllm_pkg::OP_RM_NODE,
      dllm_pkg::OP_GET_PREV, dllm_pkg::OP_GET_NEXT: act_in = n_ok_in;
      dllm_pkg::OP_INS_AFTER:                         act_in = n_ok_in && r_ok_in;
      dllm_pkg::OP_RM_HEAD, dllm_pkg::OP_GET_HEAD,
      dllm_pkg::OP_GET_TAIL:                          act_in = (cnt != '0);
      dllm_pkg::OP_RM_ALL:                            act_in = 1'b1;
      default:                                        act_in = 1'b0;
    endcase
  end

  // read addresses
  always_comb begin
    next_raddr = SENT;
    prev_raddr = SENT;
    case (state)
      ST_IDLE: begin
        case (in_opcode)
          dllm_pkg::OP_INS_AFTER: next_raddr = r_in;
          dllm_pkg::OP_RM_NODE: begin
            next_raddr = n_in;
            prev_raddr = n_in;
          end
          dllm_pkg::OP_GET_PREV: prev_raddr = n_in;
          dllm_pkg::OP_GET_NEXT: next_raddr = n_in;
          default: ;
        endcase
      end
      ST_RD1, ST_WALK: begin
        // dependent read through the entry just fetched from next
        next_raddr = next_rdata;
        prev_raddr = next_rdata;
      end
      default: ;
    endcase
  end

  // link writes
  always_comb begin
    next_we    = 1'b0;
    next_waddr = a_q;
    next_wdata = a_q;
    prev_we    = 1'b0;
    prev_waddr = a_q;
    prev_wdata = a_q;
    case (state)
      ST_CLR: begin
        next_we    = 1'b1;
        next_waddr = clr_idx;
        next_wdata = clr_idx;
        prev_we    = 1'b1;
        prev_waddr = clr_idx;
        prev_wdata = clr_idx;
      end
      ST_WR1: begin
        next_we = act_q;
        prev_we = act_q;
        case (op_q)
          dllm_pkg::OP_INS_HEAD: begin
            prev_waddr = n_q;  prev_wdata = b_q;
            next_waddr = n_q;  next_wdata = a_q;
          end
          dllm_pkg::OP_INS_TAIL: begin
            next_waddr = n_q;  next_wdata = SENT;
            prev_waddr = n_q;  prev_wdata = a_q;
          end
          dllm_pkg::OP_INS_AFTER: begin
            prev_waddr = n_q;  prev_wdata = r_q;
            next_waddr = n_q;  next_wdata = a_q;
          end
          dllm_pkg::OP_RM_HEAD: begin
            prev_waddr = b_q;  prev_wdata = SENT;
            next_waddr = SENT; next_wdata = b_q;
          end
          dllm_pkg::OP_RM_NODE: begin
            next_waddr = a_q;  next_wdata = b_q;
            prev_waddr = b_q;  prev_wdata = a_q;
          end
          default: begin
            next_we = 1'b0;
            prev_we = 1'b0;
          end
        endcase
      end
      ST_WALK: begin
        // visited entry links back to itself
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      ST_FIN: begin
        next_we = commit && act_q;
        prev_we = commit && act_q;
        case (op_q)
          dllm_pkg::OP_INS_HEAD: begin
            prev_waddr = a_q;  prev_wdata = n_q;
            next_waddr = SENT; next_wdata = n_q;
          end
          dllm_pkg::OP_INS_TAIL: begin
            next_waddr = a_q;  next_wdata = n_q;
            prev_waddr = SENT; prev_wdata = n_q;
          end
          dllm_pkg::OP_INS_AFTER: begin
            prev_waddr = a_q;  prev_wdata = n_q;
            next_waddr = r_q;  next_wdata = n_q;
          end
          dllm_pkg::OP_RM_HEAD: ;
          dllm_pkg::OP_RM_NODE: begin
            next_waddr = n_q;  next_wdata = n_q;
            prev_waddr = n_q;  prev_wdata = n_q;
          end
          dllm_pkg::OP_RM_ALL: begin
            next_waddr = SENT; next_wdata = SENT;
            prev_waddr = SENT; prev_wdata = SENT;
          end
          default: begin
            next_we = 1'b0;
            prev_we = 1'b0;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    if (act_q) begin
      if (op_q inside {dllm_pkg::OP_INS_HEAD, dllm_pkg::OP_INS_TAIL,
                       dllm_pkg::OP_INS_AFTER}) begin
        cnt_next = cnt + dllm_pkg::CNT_W'(1);
      end else if (op_q inside {dllm_pkg::OP_RM_HEAD, dllm_pkg::OP_RM_NODE}) begin
        cnt_next = cnt - dllm_pkg::CNT_W'(1);
      end else if (op_q == dllm_pkg::OP_RM_ALL) begin
        cnt_next = '0;
      end
    end
  end

  assign out_load              = commit;
  assign out_data.result_node  = dllm_pkg::NODE_W'(res_q);
  assign out_data.result_valid = resv_q;
  assign out_data.node_count   = cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      clr_idx <= '0;
      cnt     <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == SENT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RD1;
          end
        end
        ST_RD1: begin
          if (!act_q) begin
            state <= ST_FIN;
          end else begin
            case (op_q)
              dllm_pkg::OP_INS_HEAD, dllm_pkg::OP_RM_HEAD: state <= ST_RD2;
              dllm_pkg::OP_INS_TAIL, dllm_pkg::OP_INS_AFTER,
              dllm_pkg::OP_RM_NODE: state <= ST_WR1;
              dllm_pkg::OP_RM_ALL: state <= (cnt == '0) ? ST_FIN : ST_WALK;
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_RD2: state <= ST_WR1;
        ST_WR1: state <= ST_FIN;
        ST_WALK: begin
          if (rem == dllm_pkg::CNT_W'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            cnt   <= cnt_next;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // operands and fetched links
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_q   <= in_opcode;
          n_q    <= n_in;
          r_q    <= r_in;
          act_q  <= act_in;
          res_q  <= '0;
          resv_q <= 1'b0;
        end
      end
      ST_RD1: begin
        rem <= cnt;
        case (op_q)
          dllm_pkg::OP_INS_TAIL: a_q <= prev_rdata;
          dllm_pkg::OP_RM_NODE: begin
            a_q <= prev_rdata;
            b_q <= next_rdata;
          end
          dllm_pkg::OP_RM_HEAD, dllm_pkg::OP_GET_HEAD: begin
            a_q <= next_rdata;
            if (act_q && next_rdata != SENT) begin
              res_q  <= next_rdata;
              resv_q <= 1'b1;
            end
          end
          dllm_pkg::OP_GET_TAIL: begin
            if (act_q && prev_rdata != SENT) begin
              res_q  <= prev_rdata;
              resv_q <= 1'b1;
            end
          end
          dllm_pkg::OP_GET_PREV: begin
            if (act_q && prev_rdata != SENT && prev_rdata != n_q) begin
              res_q  <= prev_rdata;
              resv_q <= 1'b1;
            end
          end
          dllm_pkg::OP_GET_NEXT: begin
            if (act_q && next_rdata != SENT && next_rdata != n_q) begin
              res_q  <= next_rdata;
              resv_q <= 1'b1;
            end
          end
          default: a_q <= next_rdata;
        endcase
      end
      ST_RD2: begin
        b_q <= (op_q == dllm_pkg::OP_INS_HEAD) ? prev_rdata : next_rdata;
      end
      ST_WALK: begin
        a_q <= next_rdata;
        rem <= rem - dllm_pkg::CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/doubly_linked_list_manager_unit.sv =====
// states from accept: queries, unused opcodes and ops that find nothing to do RD1, FIN;
//   insert at tail, insert after a reference and remove node RD1, WR1, FIN; insert at head
//   and remove head RD1, RD2, WR1, FIN; remove all RD1, WALK over node_count entries, FIN
// throughput: one transaction at a time, set by the dependent link reads and the
//   two rounds of link writes through the single write port of each link memory
// reset: synchronous, active high; a clearing pass then links every entry to itself,
//   all NODE_POOL + 1 of them, with s_tready low until it is done
`timescale 1ns / 1ps

module doubly_linked_list_manager_unit #(
  parameter int unsigned NODE_POOL = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request transactions
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // opcode [3:0], node [9:4], ref_node [15:10]
  // result transactions
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result_node [5:0], node_count [12:6], zero [15:13]
  output logic [0:0]  m_tuser    // result_valid [0]
);

  // link entries 0..NODE_POOL-1 are nodes, entry NODE_POOL is the sentinel
  localparam int unsigned AW = $clog2(NODE_POOL + 1);

  logic          next_we;
  logic [AW-1:0] next_waddr;
  logic [AW-1:0] next_wdata;
  logic [AW-1:0] next_raddr;
  logic [AW-1:0] next_rdata;
  logic          prev_we;
  logic [AW-1:0] prev_waddr;
  logic [AW-1:0] prev_wdata;
  logic [AW-1:0] prev_raddr;
  logic [AW-1:0] prev_rdata;

  logic              out_free;
  logic              out_load;
  dllm_pkg::result_t out_data;
  dllm_pkg::result_t m_data;

  // sequencer: read, read the dependent link, then write back in two rounds
  dllm_seq #(
    .NODE_POOL (NODE_POOL),
    .AW        (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_opcode  (s_tdata[3:0]),
    .in_node    (s_tdata[9:4]),
    .in_ref     (s_tdata[15:10]),
    .out_free   (out_free),
    .out_load   (out_load),
    .out_data   (out_data),
    .next_we    (next_we),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .next_raddr (next_raddr),
    .next_rdata (next_rdata),
    .prev_we    (prev_we),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .prev_raddr (prev_raddr),
    .prev_rdata (prev_rdata)
  );

  // next link table
  dllm_link_ram #(
    .AW    (AW),
    .DEPTH (NODE_POOL + 1)
  ) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  // prev link table
  dllm_link_ram #(
    .AW    (AW),
    .DEPTH (NODE_POOL + 1)
  ) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  // result register, a result may wait here while the next request is taken
  dllm_out_slot u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (out_data),
    .free      (out_free),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_data    (m_data)
  );

  assign m_tdata = {3'b000, m_data.node_count, m_data.result_node};
  assign m_tuser = m_data.result_valid;

endmodule

// ===== verif/doubly_linked_list_manager_unit_tb.sv =====
`timescale 1ns / 1ps

module doubly_linked_list_manager_unit_tb;

  localparam int unsigned POOL       = 64;
  localparam int unsigned SENT       = POOL;      // sentinel entry of the link tables
  localparam int unsigned RANDOM_OPS = 700;
  // remove all can walk a wrapped count of 127 entries, so the drain allows for that
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // opcode [3:0], node [9:4], ref_node [15:10]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // result_node [5:0], node_count [12:6], zero [15:13]
  logic [0:0]  m_tuser;        // result_valid [0]

  doubly_linked_list_manager_unit #(.NODE_POOL(POOL)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the list: forward and backward links plus the node count
  logic [6:0] fwd_link [0:POOL];
  logic [6:0] bwd_link [0:POOL];
  logic [6:0] list_count;

  logic [15:0]       list_requests [$];          // request transactions not yet driven
  dllm_pkg::result_t expected_list_results [$];  // results owed by accepted requests

  int unsigned issued_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned result_cnt    = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned src_gap       = 0;
  int unsigned src_calm      = 0;
  int unsigned sink_stall    = 0;
  int unsigned sink_calm     = 0;
  dllm_pkg::result_t want;

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // apply one operation to the shadow list and return the result it owes
  function automatic dllm_pkg::result_t apply_list_op(logic [3:0] opc, logic [5:0] nd,
                                                      logic [5:0] rn);
    dllm_pkg::result_t res;
    logic [6:0] n, r, hd, tl, nb, pv, cur, walk;
    int         k;
    res = '0;
    n   = {1'b0, nd};
    r   = {1'b0, rn};
    case (opc)
      dllm_pkg::OP_INS_HEAD: begin
        // the new node's backward link is copied from the old head
        hd = fwd_link[SENT];
        bwd_link[n] = bwd_link[hd];
        fwd_link[n] = hd;
        bwd_link[hd] = n;
        fwd_link[SENT] = n;
        list_count = list_count + 7'd1;
      end
      dllm_pkg::OP_INS_TAIL: begin
        tl = bwd_link[SENT];
        fwd_link[n] = 7'(SENT);
        bwd_link[n] = tl;
        fwd_link[tl] = n;
        bwd_link[SENT] = n;
        list_count = list_count + 7'd1;
      end
      dllm_pkg::OP_INS_AFTER: begin
        nb = fwd_link[r];
        bwd_link[n] = r;
        fwd_link[n] = nb;
        bwd_link[nb] = n;
        fwd_link[r] = n;
        list_count = list_count + 7'd1;
      end
      dllm_pkg::OP_RM_HEAD: begin
        if (list_count != 0) begin
          hd = fwd_link[SENT];
          nb = fwd_link[hd];
          bwd_link[nb] = 7'(SENT);
          fwd_link[SENT] = nb;
          list_count = list_count - 7'd1;
          fwd_link[hd] = hd;
          bwd_link[hd] = hd;
          // a corrupted list can hand back the sentinel itself
          if (hd != SENT) begin
            res.result_valid = 1'b1;
            res.result_node  = hd[5:0];
          end
        end
      end
      dllm_pkg::OP_RM_NODE: begin
        // no membership check: an unlinked node still costs a count
        pv = bwd_link[n];
        nb = fwd_link[n];
        fwd_link[pv] = nb;
        bwd_link[nb] = pv;
        list_count = list_count - 7'd1;
        fwd_link[n] = n;
        bwd_link[n] = n;
      end
      dllm_pkg::OP_RM_ALL: begin
        // walk count steps forward, freeing each visited entry
        walk = fwd_link[SENT];
        for (k = int'(list_count); k != 0; k--) begin
          cur = walk;
          walk = fwd_link[cur];
          fwd_link[cur] = cur;
          bwd_link[cur] = cur;
        end
        fwd_link[SENT] = 7'(SENT);
        bwd_link[SENT] = 7'(SENT);
        list_count = '0;
      end
      dllm_pkg::OP_GET_HEAD, dllm_pkg::OP_GET_TAIL: begin
        if (list_count != 0) begin
          cur = (opc == dllm_pkg::OP_GET_HEAD) ? fwd_link[SENT] : bwd_link[SENT];
          if (cur != SENT) begin
            res.result_valid = 1'b1;
            res.result_node  = cur[5:0];
          end
        end
      end
      dllm_pkg::OP_GET_PREV, dllm_pkg::OP_GET_NEXT: begin
        // a self link means the node is not in the list
        cur = (opc == dllm_pkg::OP_GET_PREV) ? bwd_link[n] : fwd_link[n];
        if (cur != SENT && cur != n) begin
          res.result_valid = 1'b1;
          res.result_node  = cur[5:0];
        end
      end
      default: ;   // unused opcodes leave everything alone
    endcase
    res.node_count = list_count;
    return res;
  endfunction

  function automatic bit is_linked(logic [5:0] nd);
    return fwd_link[{1'b0, nd}] != {1'b0, nd} || bwd_link[{1'b0, nd}] != {1'b0, nd};
  endfunction

  // random node, preferably one that is (or is not) currently in the list
  function automatic logic [5:0] pick_node(bit want_linked);
    logic [5:0] cand;
    cand = 6'($urandom);
    for (int i = 0; i < 32; i++) begin
      if (is_linked(cand) == want_linked)
        return cand;
      cand = 6'($urandom);
    end
    return cand;
  endfunction

  // idle length: mostly short, a few long, and now and then a calm stretch
  function automatic int unsigned pick_idle(ref int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      calm = $urandom_range(60, 20);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // mostly well formed operations against the current list, some raw noise
  function automatic logic [15:0] make_request();
    logic [3:0]  opc;
    logic [5:0]  nd, rn;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12)
      return 16'($urandom);   // any opcode, duplicate inserts, stray removes
    nd   = pick_node(1'b0);
    rn   = pick_node(1'b1);
    roll = $urandom_range(99);
    // crowded pool: steer inserts toward removes and queries
    if (list_count >= 7'd56 && roll < 42)
      roll = roll + 42;
    if (roll < 14)
      opc = dllm_pkg::OP_INS_HEAD;
    else if (roll < 28)
      opc = dllm_pkg::OP_INS_TAIL;
    else if (roll < 42)
      opc = (list_count == 0) ? dllm_pkg::OP_INS_TAIL : dllm_pkg::OP_INS_AFTER;
    else if (roll < 52)
      opc = dllm_pkg::OP_RM_HEAD;
    else if (roll < 66) begin
      opc = dllm_pkg::OP_RM_NODE;
      nd  = pick_node(1'b1);
    end else if (roll < 68)
      opc = dllm_pkg::OP_RM_ALL;
    else if (roll < 74)
      opc = dllm_pkg::OP_GET_HEAD;
    else if (roll < 80)
      opc = dllm_pkg::OP_GET_TAIL;
    else begin
      opc = (roll < 90) ? dllm_pkg::OP_GET_PREV : dllm_pkg::OP_GET_NEXT;
      nd  = ($urandom_range(3) == 0) ? 6'($urandom) : pick_node(1'b1);
    end
    return {rn, nd, opc};
  endfunction

  task automatic push_req(input logic [3:0] opc, input logic [5:0] nd, input logic [5:0] rn);
    list_requests.push_back({rn, nd, opc});
    issued_cnt++;
  endtask

  // request driver: one transaction at a time, random gap after each
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_list_results.push_back(
          apply_list_op(s_tdata[3:0], s_tdata[9:4], s_tdata[15:10]));
        accepted_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (list_requests.size() != 0) begin
          s_tdata  <= list_requests.pop_front();
          s_tvalid <= 1'b1;
          src_gap = pick_idle(src_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure, in-order field compare
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_list_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction data %h user %b",
                                    m_tdata, m_tuser));
        end else begin
          want = expected_list_results.pop_front();
          if (m_tdata[5:0] !== want.result_node)
            report_mismatch($sformatf("result %0d result_node got %0d expected %0d",
                                      result_cnt, m_tdata[5:0], want.result_node));
          if (m_tuser[0] !== want.result_valid)
            report_mismatch($sformatf("result %0d result_valid got %b expected %b",
                                      result_cnt, m_tuser[0], want.result_valid));
          if (m_tdata[12:6] !== want.node_count)
            report_mismatch($sformatf("result %0d node_count got %0d expected %0d",
                                      result_cnt, m_tdata[12:6], want.node_count));
        end
        result_cnt++;
      end
      if (sink_stall != 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(99) < 30)
          sink_stall = pick_idle(sink_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i <= POOL; i++) begin
      fwd_link[i] = 7'(i);
      bwd_link[i] = 7'(i);
    end
    list_count = '0;

    // directed: empty list, edge nodes, neighbors at the sentinel, unchecked
    // insert and remove, count wrap below zero, sentinel reached, unused opcodes
    push_req(dllm_pkg::OP_GET_HEAD,  6'd0,  6'd0);
    push_req(dllm_pkg::OP_GET_TAIL,  6'd0,  6'd0);
    push_req(dllm_pkg::OP_RM_HEAD,   6'd0,  6'd0);
    push_req(dllm_pkg::OP_GET_PREV,  6'd0,  6'd0);
    push_req(dllm_pkg::OP_GET_NEXT,  6'd63, 6'd63);
    push_req(dllm_pkg::OP_INS_HEAD,  6'd0,  6'd0);
    push_req(dllm_pkg::OP_INS_TAIL,  6'd63, 6'd0);
    push_req(dllm_pkg::OP_INS_AFTER, 6'd21, 6'd0);
    push_req(dllm_pkg::OP_INS_HEAD,  6'd42, 6'd63);
    push_req(dllm_pkg::OP_GET_HEAD,  6'd0,  6'd0);
    push_req(dllm_pkg::OP_GET_TAIL,  6'd0,  6'd0);
    push_req(dllm_pkg::OP_GET_PREV,  6'd21, 6'd0);
    push_req(dllm_pkg::OP_GET_NEXT,  6'd21, 6'd0);
    push_req(dllm_pkg::OP_GET_NEXT,  6'd63, 6'd0);
    push_req(dllm_pkg::OP_GET_PREV,  6'd42, 6'd0);
    push_req(dllm_pkg::OP_RM_NODE,   6'd21, 6'd0);
    push_req(dllm_pkg::OP_RM_HEAD,   6'd0,  6'd0);
    push_req(dllm_pkg::OP_INS_TAIL,  6'd0,  6'd0);    // node already linked
    push_req(dllm_pkg::OP_RM_NODE,   6'd5,  6'd0);    // node not linked
    push_req(4'hF,                   6'd63, 6'd63);
    push_req(4'hA,                   6'd0,  6'd0);
    push_req(dllm_pkg::OP_RM_ALL,    6'd0,  6'd0);
    push_req(dllm_pkg::OP_RM_NODE,   6'd7,  6'd0);    // count wraps down to 127
    push_req(dllm_pkg::OP_GET_HEAD,  6'd0,  6'd0);    // lands on the sentinel
    push_req(dllm_pkg::OP_RM_HEAD,   6'd0,  6'd0);    // lands on the sentinel
    push_req(dllm_pkg::OP_RM_ALL,    6'd0,  6'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // random part, generated against the shadow list as it evolves
    repeat (RANDOM_OPS) begin
      while (list_requests.size() != 0)
        @(negedge clk);
      list_requests.push_back(make_request());
      issued_cnt++;
    end

    while (accepted_cnt != issued_cnt || expected_list_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
